FILE: design/bcsm_pkg.sv
// Shared types and constants for the batch cache slot manager.
// No dependencies; used by bcsm_ram consumers and the top level.
package bcsm_pkg;

  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned CFG_W        = 7;
  localparam int unsigned KEY_W        = 64;
  localparam int unsigned SLOT_W       = 6;

  localparam logic [CFG_W-1:0] MAX_CACHED_RST = 7'd64;
  localparam logic [KEY_W-1:0] TAG_BASE       = 64'h4000_0000_0000_0000;

  localparam int unsigned IN_DATA_W  = 264;
  localparam int unsigned OUT_DATA_W = 80;

  typedef enum logic [1:0] {
    OUT_HIT      = 2'd0,
    OUT_REBUILT  = 2'd1,
    OUT_REJECTED = 2'd2,
    OUT_NO_SLOT  = 2'd3
  } outcome_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [KEY_W-1:0] last_used;
    logic             ready;
    logic [KEY_W-1:0] signature;
    logic [KEY_W-1:0] material;
    logic             kind;
    logic [KEY_W-1:0] key;
  } entry_t;

endpackage

FILE: design/bcsm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package dependencies.
module bcsm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

FILE: design/batch_cache_slot_manager.sv
// Batch cache slot manager: LRU cache of batch entries held in one RAM.
// Depends on bcsm_pkg and bcsm_ram.
//
// Channel   Dir  Handshake          Payload (low bit first)
// s_axis    in   tvalid/tready      tdata: key, material, signature, frame, build_ok
//                                   tuser: batch_kind
// m_axis    out  tvalid/tready      tdata: slot, outcome, recycled, created, batch_tag
// cfg       in   cfg_wr_en_i        cfg_wr_data_i: max_cached_batches
//
// An item is accepted, then the scan reads each stored entry in turn through
// the single read port and compares the registered read data; the scan then
// closes, and the write-back stage writes the entry and loads the result. A
// key match ends the scan early. Reset empties the cache by clearing the entry
// count. The result register lets the next item be accepted while a result
// waits; a stalled output holds the write-back of the following item.
module batch_cache_slot_manager
  import bcsm_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_wr_en_i,
  input  logic [CFG_W-1:0]      cfg_wr_data_i,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // key[63:0], material[127:64], signature[191:128], frame[255:192],
  // build_ok[256], zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // batch_kind[0]
  input  logic                  s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // slot[5:0], outcome[7:6], recycled[8], created[9], batch_tag[73:10], zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  localparam int unsigned AW   = $clog2(CAPACITY);
  localparam int unsigned IW   = $clog2(CAPACITY + 1);
  localparam int unsigned CW   = (IW > CFG_W) ? IW : CFG_W;
  localparam int unsigned SW   = (AW > SLOT_W) ? AW : SLOT_W;
  localparam int unsigned ENT_W = $bits(entry_t);

  state_e            state_q, state_d;
  logic [CFG_W-1:0]  max_q;
  logic [IW-1:0]     cnt_q, cnt_d;
  logic [IW-1:0]     rd_idx_q, rd_idx_d;
  logic              cmp_vld_q, cmp_vld_d;
  logic [AW-1:0]     cmp_idx_q, cmp_idx_d;
  logic              found_q, found_d;
  logic              have_q, have_d;
  logic              out_vld_q, out_vld_d;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;

  logic [KEY_W-1:0]  key_q, mat_q, sig_q, frame_q;
  logic              kind_q, bok_q;
  logic [AW-1:0]     m_idx_q, m_idx_d;
  logic [KEY_W-1:0]  m_sig_q, m_sig_d, m_last_q, m_last_d;
  logic              m_rdy_q, m_rdy_d;
  logic [AW-1:0]     v_idx_q, v_idx_d;
  logic [KEY_W-1:0]  v_last_q, v_last_d, oldest_q, oldest_d;
  logic              v_rdy_q, v_rdy_d;

  logic              accept, match, rd_en, out_free, load;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  entry_t            ram_wdata, ent;
  logic [ENT_W-1:0]  ram_rdata;

  logic [CW-1:0]     lim, cnt_ext;
  logic              got, rec, cre, hit;
  logic [AW-1:0]     slot;
  logic [SW-1:0]     slot_ext;
  logic [KEY_W-1:0]  s_sig, s_last, tag;
  logic              s_rdy;
  outcome_e          outcome;

  bcsm_ram #(
    .WIDTH (ENT_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_idx_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign ent             = entry_t'(ram_rdata);
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign out_free        = !out_vld_q || m_axis_tready_i;

  assign match = cmp_vld_q && (ent.key == key_q) && (ent.kind == kind_q) &&
                 (ent.material == mat_q);
  assign rd_en = (state_q == ST_SCAN) && (rd_idx_q < cnt_q) && !match;

  // Pick the slot, outcome and write-back entry from the scan results.
  always_comb begin
    cnt_ext = CW'(cnt_q);
    lim     = CW'(max_q);
    if (lim == '0) begin
      lim = CW'(1);
    end
    if (lim > CW'(CAPACITY)) begin
      lim = CW'(CAPACITY);
    end
    got    = 1'b1;
    rec    = 1'b0;
    cre    = 1'b0;
    slot   = m_idx_q;
    s_sig  = m_sig_q;
    s_rdy  = m_rdy_q;
    s_last = m_last_q;
    priority if (found_q) begin
    end else if ((cnt_ext >= lim) && have_q) begin
      rec    = 1'b1;
      slot   = v_idx_q;
      s_sig  = '0;
      s_rdy  = v_rdy_q;
      s_last = v_last_q;
    end else if (cnt_q < IW'(CAPACITY)) begin
      cre    = 1'b1;
      slot   = cnt_q[AW-1:0];
      s_sig  = '0;
      s_rdy  = 1'b0;
      s_last = '0;
    end else begin
      got = 1'b0;
    end
    hit = (s_sig == sig_q) && s_rdy;
    priority if (!got) begin
      outcome = OUT_NO_SLOT;
    end else if (hit) begin
      outcome = OUT_HIT;
    end else if (bok_q) begin
      outcome = OUT_REBUILT;
    end else begin
      outcome = OUT_REJECTED;
    end
    tag = ((outcome == OUT_HIT) || (outcome == OUT_REBUILT)) ?
          (TAG_BASE ^ key_q ^ sig_q) : '0;
    slot_ext = got ? SW'(slot) : '0;

    ram_wdata.key       = key_q;
    ram_wdata.kind      = kind_q;
    ram_wdata.material  = mat_q;
    ram_wdata.signature = (outcome == OUT_REBUILT) ? sig_q : s_sig;
    ram_wdata.ready     = (outcome == OUT_REJECTED) ? s_rdy : 1'b1;
    ram_wdata.last_used = (outcome == OUT_REJECTED) ? s_last : frame_q;
    ram_waddr           = slot;
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    rd_idx_d   = rd_idx_q;
    cmp_vld_d  = 1'b0;
    cmp_idx_d  = rd_idx_q[AW-1:0];
    found_d    = found_q;
    have_d     = have_q;
    m_idx_d    = m_idx_q;
    m_sig_d    = m_sig_q;
    m_rdy_d    = m_rdy_q;
    m_last_d   = m_last_q;
    v_idx_d    = v_idx_q;
    v_rdy_d    = v_rdy_q;
    v_last_d   = v_last_q;
    oldest_d   = oldest_q;
    load       = 1'b0;
    ram_we     = 1'b0;
    out_data_d = out_data_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          rd_idx_d = '0;
          found_d  = 1'b0;
          have_d   = 1'b0;
          oldest_d = '1;
          state_d  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmp_vld_d = rd_en;
        if (rd_en) begin
          rd_idx_d = rd_idx_q + IW'(1);
        end
        if (cmp_vld_q && (ent.last_used != frame_q) && (ent.last_used < oldest_q)) begin
          oldest_d = ent.last_used;
          have_d   = 1'b1;
          v_idx_d  = cmp_idx_q;
          v_rdy_d  = ent.ready;
          v_last_d = ent.last_used;
        end
        if (match) begin
          found_d  = 1'b1;
          m_idx_d  = cmp_idx_q;
          m_sig_d  = ent.signature;
          m_rdy_d  = ent.ready;
          m_last_d = ent.last_used;
          state_d  = ST_DONE;
        end else if (!rd_en && !cmp_vld_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          load       = 1'b1;
          ram_we     = got;
          out_data_d = {6'b0, tag, cre, rec, outcome, slot_ext[SLOT_W-1:0]};
          if (cre) begin
            cnt_d = cnt_q + IW'(1);
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    out_vld_d = (out_vld_q && !m_axis_tready_i) || load;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      max_q     <= MAX_CACHED_RST;
      cnt_q     <= '0;
      rd_idx_q  <= '0;
      cmp_vld_q <= 1'b0;
      found_q   <= 1'b0;
      have_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      rd_idx_q  <= rd_idx_d;
      cmp_vld_q <= cmp_vld_d;
      found_q   <= found_d;
      have_q    <= have_d;
      out_vld_q <= out_vld_d;
      if (cfg_wr_en_i) begin
        max_q <= cfg_wr_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q   <= s_axis_tdata_i[63:0];
      mat_q   <= s_axis_tdata_i[127:64];
      sig_q   <= s_axis_tdata_i[191:128];
      frame_q <= s_axis_tdata_i[255:192];
      bok_q   <= s_axis_tdata_i[256];
      kind_q  <= s_axis_tuser_i;
    end
    cmp_idx_q  <= cmp_idx_d;
    m_idx_q    <= m_idx_d;
    m_sig_q    <= m_sig_d;
    m_rdy_q    <= m_rdy_d;
    m_last_q   <= m_last_d;
    v_idx_q    <= v_idx_d;
    v_rdy_q    <= v_rdy_d;
    v_last_q   <= v_last_d;
    oldest_q   <= oldest_d;
    out_data_q <= out_data_d;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= IW'(CAPACITY))
    else $error("entry count above capacity");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |-> (cnt_q == $past(cnt_q) + IW'(1)))
    else $error("entry count changed by more than one");

  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && rd_en))
    else $error("RAM write overlaps a scan read");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> ($past(state_q) == ST_DONE))
    else $error("result loaded outside write-back");

endmodule

FILE: dv/tb.sv
// Testbench for batch_cache_slot_manager: random and directed lookup requests
// are checked against an internal LRU slot predictor. Depends on bcsm_pkg.
`timescale 1ns / 1ps

module tb;
  import bcsm_pkg::*;

  typedef struct {
    logic [KEY_W-1:0] key;
    logic             kind;
    logic [KEY_W-1:0] material;
    logic [KEY_W-1:0] signature;
    logic [KEY_W-1:0] frame;
    logic             build_ok;
  } cache_req_t;

  typedef struct {
    logic [SLOT_W-1:0] slot;
    outcome_e          outcome;
    logic              recycled;
    logic              created;
    logic [KEY_W-1:0]  tag;
  } slot_grant_t;

  typedef enum {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} rx_mode_e;

  localparam int POOL = 128;

  class slot_tracker;
    logic [CFG_W-1:0] limit_reg = MAX_CACHED_RST;
    int unsigned      count = 0;
    logic [KEY_W-1:0] e_key       [CAPACITY_DEF];
    logic             e_kind      [CAPACITY_DEF];
    logic [KEY_W-1:0] e_material  [CAPACITY_DEF];
    logic [KEY_W-1:0] e_signature [CAPACITY_DEF];
    logic             e_ready     [CAPACITY_DEF];
    logic [KEY_W-1:0] e_last_used [CAPACITY_DEF];
    slot_grant_t      pending_grants[$];
    int               errors = 0;
    int               n_checked = 0;
    int               n_outcome [4];
    int               n_recycled = 0;
    int               n_created = 0;

    function new();
      foreach (e_ready[i]) e_ready[i] = 1'b0;
      foreach (n_outcome[i]) n_outcome[i] = 0;
    endfunction

    function void note_request(cache_req_t r);
      slot_grant_t      g;
      int unsigned      lim;
      int unsigned      idx;
      bit               found;
      bit               have;
      logic [KEY_W-1:0] oldest;
      idx = 0;
      found = 1'b0;
      g.recycled = 1'b0;
      g.created = 1'b0;
      g.tag = '0;
      for (int i = 0; i < count; i++) begin
        if (e_key[i] == r.key && e_kind[i] == r.kind && e_material[i] == r.material) begin
          idx = i;
          found = 1'b1;
          break;
        end
      end
      if (!found) begin
        lim = limit_reg;
        if (lim == 0) lim = 1;
        if (lim > CAPACITY_DEF) lim = CAPACITY_DEF;
        if (count >= lim) begin
          oldest = '1;
          have = 1'b0;
          for (int i = 0; i < count; i++) begin
            if (e_last_used[i] != r.frame && e_last_used[i] < oldest) begin
              oldest = e_last_used[i];
              idx = i;
              have = 1'b1;
            end
          end
          if (have) begin
            e_key[idx] = r.key;
            e_kind[idx] = r.kind;
            e_material[idx] = r.material;
            e_signature[idx] = '0;
            g.recycled = 1'b1;
            found = 1'b1;
          end
        end
        if (!found && count < CAPACITY_DEF) begin
          idx = count;
          e_key[idx] = r.key;
          e_kind[idx] = r.kind;
          e_material[idx] = r.material;
          e_signature[idx] = '0;
          e_ready[idx] = 1'b0;
          e_last_used[idx] = '0;
          count++;
          g.created = 1'b1;
          found = 1'b1;
        end
      end
      if (!found) begin
        g.slot = '0;
        g.outcome = OUT_NO_SLOT;
        g.recycled = 1'b0;
        g.created = 1'b0;
      end else begin
        g.slot = idx[SLOT_W-1:0];
        if (e_signature[idx] == r.signature && e_ready[idx]) begin
          g.outcome = OUT_HIT;
        end else if (r.build_ok) begin
          e_signature[idx] = r.signature;
          e_ready[idx] = 1'b1;
          g.outcome = OUT_REBUILT;
        end else begin
          g.outcome = OUT_REJECTED;
        end
        if (g.outcome != OUT_REJECTED) begin
          e_last_used[idx] = r.frame;
          g.tag = TAG_BASE ^ r.key ^ r.signature;
        end
      end
      pending_grants.insert(pending_grants.size(), g);
    endfunction

    function void check_grant(logic [OUT_DATA_W-1:0] d);
      slot_grant_t got;
      slot_grant_t want;
      got.slot = d[5:0];
      got.outcome = outcome_e'(d[7:6]);
      got.recycled = d[8];
      got.created = d[9];
      got.tag = d[73:10];
      if (pending_grants.size() == 0) begin
        errors++;
        $error("unexpected result transfer: slot %0d outcome %0d", got.slot, got.outcome);
        return;
      end
      want = pending_grants.pop_front();
      n_checked++;
      n_outcome[want.outcome]++;
      if (want.recycled) n_recycled++;
      if (want.created) n_created++;
      if (got.slot !== want.slot) begin
        errors++;
        $error("slot: expected %0d, got %0d", want.slot, got.slot);
      end
      if (got.outcome !== want.outcome) begin
        errors++;
        $error("outcome: expected %0d, got %0d", want.outcome, got.outcome);
      end
      if (got.recycled !== want.recycled) begin
        errors++;
        $error("recycled: expected %0d, got %0d", want.recycled, got.recycled);
      end
      if (got.created !== want.created) begin
        errors++;
        $error("created: expected %0d, got %0d", want.created, got.created);
      end
      if (got.tag !== want.tag) begin
        errors++;
        $error("batch_tag: expected %h, got %h", want.tag, got.tag);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_W-1:0]      cfg_wr_data;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;

  slot_tracker      tracker = new();
  logic [KEY_W-1:0] pool_key  [POOL];
  logic             pool_kind [POOL];
  logic [KEY_W-1:0] pool_mat  [POOL];
  logic [KEY_W-1:0] pool_sig  [POOL];
  logic [KEY_W-1:0] frame_now = 64'd10;
  int               burst_left = 0;
  int               hold_cycles = 0;
  int               n_settings = 0;

  always #4 clk = ~clk;

  batch_cache_slot_manager dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_wr_en_i     (cfg_wr_en),
    .cfg_wr_data_i   (cfg_wr_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  function automatic cache_req_t mk_req(logic [KEY_W-1:0] key, logic kind,
                                        logic [KEY_W-1:0] mat, logic [KEY_W-1:0] sig,
                                        logic [KEY_W-1:0] frame, logic build_ok);
    cache_req_t r;
    r.key = key;
    r.kind = kind;
    r.material = mat;
    r.signature = sig;
    r.frame = frame;
    r.build_ok = build_ok;
    return r;
  endfunction

  function automatic logic [KEY_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic write_limit(input logic [CFG_W-1:0] v);
    cfg_wr_en = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    tracker.limit_reg = v;
    n_settings++;
  endtask

  // Hold the transfer until accepted, then idle for a random, possibly empty, gap between bursts.
  task automatic offer(input cache_req_t r);
    int gap;
    s_tvalid = 1'b1;
    s_tuser = r.kind;
    s_tdata = {{(IN_DATA_W - 257){1'b0}}, r.build_ok, r.frame, r.signature,
               r.material, r.key};
    do @(posedge clk); while (!s_tready);
    tracker.note_request(r);
    @(negedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 32);
    end
  endtask

  task automatic drain();
    s_tvalid = 1'b0;
    while (tracker.pending_grants.size() != 0) @(posedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] lim, input int n_items, input int win,
                           input int run_lo, input int run_hi);
    int         sent;
    int         len;
    int         start;
    int         pbase;
    int         idx;
    bit         sweep;
    cache_req_t r;
    write_limit(lim);
    sent = 0;
    pbase = $urandom_range(0, POOL - 1);
    while (sent < n_items) begin
      len = $urandom_range(run_lo, run_hi);
      case ($urandom_range(0, 19))
        0, 1: frame_now = rand64();
        2: frame_now = '1;
        3: ;
        default: frame_now = frame_now + 1;
      endcase
      sweep = ($urandom_range(0, 1) == 0);
      start = $urandom_range(0, win - 1);
      for (int j = 0; j < len && sent < n_items; j++) begin
        if (sweep) idx = (pbase + (start + j) % win) % POOL;
        else idx = (pbase + $urandom_range(0, win - 1)) % POOL;
        if ($urandom_range(0, 6) == 0) pool_sig[idx] = rand64();
        r = mk_req(pool_key[idx], pool_kind[idx], pool_mat[idx], pool_sig[idx], frame_now,
                   $urandom_range(0, 9) != 0);
        // stray key outside the working set
        if ($urandom_range(0, 24) == 0) begin
          r.key = rand64();
          r.kind = 1'($urandom_range(0, 1));
          r.material = rand64();
          r.signature = rand64();
        end
        offer(r);
        sent++;
      end
    end
  endtask

  initial begin : rx_side
    rx_mode_e mode;
    int       mode_left;
    m_tready = 1'b0;
    mode = RX_OPEN;
    mode_left = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        m_tready = 1'b0;
        hold_cycles--;
      end else begin
        if (mode_left == 0) begin
          mode = rx_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(100, 500);
        end
        mode_left--;
        case (mode)
          RX_OPEN:     m_tready = 1'b1;
          RX_MOSTLY:   m_tready = ($urandom_range(0, 3) != 0);
          RX_SPARSE:   m_tready = ($urandom_range(0, 3) == 0);
          RX_PERIODIC: m_tready = (mode_left % 4 != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && m_tvalid && m_tready) tracker.check_grant(m_tdata);
  end

  initial begin : watchdog
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    logic [KEY_W-1:0] ones;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = MAX_CACHED_RST;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    ones = '1;
    foreach (pool_key[i]) begin
      pool_key[i] = rand64();
      pool_kind[i] = 1'($urandom_range(0, 1));
      pool_mat[i] = rand64();
      pool_sig[i] = rand64();
    end
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // zero limit acts as one; walk through reject, rebuild, hit and recycling
    write_limit(7'd0);
    offer(mk_req(ones, 1'b1, ones, pool_sig[0], 64'd1, 1'b0));
    offer(mk_req(ones, 1'b1, ones, pool_sig[0], 64'd1, 1'b1));
    offer(mk_req(ones, 1'b1, ones, pool_sig[0], 64'd1, 1'b1));
    offer(mk_req('0, 1'b0, '0, '0, 64'd1, 1'b1));
    offer(mk_req(pool_key[0], pool_kind[0], pool_mat[0], '0, 64'd2, 1'b1));
    offer(mk_req(ones, 1'b1, ones, pool_sig[0], 64'd2, 1'b0));
    offer(mk_req(pool_key[1], pool_kind[1], pool_mat[1], pool_sig[1], 64'd2, 1'b1));
    offer(mk_req(pool_key[2], pool_kind[2], pool_mat[2], pool_sig[2], ones, 1'b1));
    offer(mk_req(pool_key[3], pool_kind[3], pool_mat[3], pool_sig[3], ones, 1'b1));
    offer(mk_req(pool_key[4], pool_kind[4], pool_mat[4], pool_sig[4], 64'd3, 1'b1));
    offer(mk_req(pool_key[4], pool_kind[4], pool_mat[4], pool_sig[4], 64'd3, 1'b1));
    drain();
    // limit above capacity saturates
    write_limit(7'd127);
    offer(mk_req(pool_key[5], 1'b0, pool_mat[5], ones, 64'd0, 1'b1));
    offer(mk_req(pool_key[5], 1'b0, pool_mat[5], ones, 64'd0, 1'b1));
    offer(mk_req(pool_key[5], 1'b1, pool_mat[5], ones, 64'd0, 1'b0));
    drain();

    run_phase(7'd1, 150, 6, 1, 8);
    drain();
    run_phase(7'd2, 150, 8, 1, 8);
    drain();
    run_phase(7'd5, 200, 12, 1, 10);
    drain();
    // stall the output long enough to back up the input
    hold_cycles = 400;
    run_phase(7'd127, 300, 96, 20, 90);
    drain();
    run_phase(7'd64, 250, 96, 1, 80);
    drain();
    run_phase(7'd16, 200, 24, 1, 20);
    drain();
    run_phase(7'd0, 100, 4, 1, 4);
    drain();
    run_phase(CFG_W'($urandom_range(0, 127)), 150, $urandom_range(2, 96), 1, 40);
    drain();
    repeat (80) @(posedge clk);

    $display("checked %0d results over %0d limit settings: %0d hit, %0d rebuilt, %0d rejected",
             tracker.n_checked, n_settings, tracker.n_outcome[OUT_HIT],
             tracker.n_outcome[OUT_REBUILT], tracker.n_outcome[OUT_REJECTED]);
    $display("%0d no-slot, %0d recycled, %0d created entries",
             tracker.n_outcome[OUT_NO_SLOT], tracker.n_recycled, tracker.n_created);
    if (tracker.errors == 0 && tracker.pending_grants.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/bcsm_pkg.sv
design/bcsm_ram.sv
design/batch_cache_slot_manager.sv
dv/tb.sv
